// File: hw/rtl/fdrs_pkg.sv
// Shared types and constants for the recent distinct id set.
`default_nettype none

package fdrs_pkg;

  // Fixed field widths
  localparam int unsigned IdW = 32;
  localparam int unsigned CountW = 6;
  localparam int unsigned DefMaxEntries = 32;

  // Stream payload widths
  localparam int unsigned InTdataW = 32;
  localparam int unsigned OutTdataW = 80;

  // Input selector codes
  localparam logic OpOffer = 1'b0;
  localparam logic OpDump = 1'b1;

  // Result kind codes
  localparam logic KindOffer = 1'b0;
  localparam logic KindDump = 1'b1;

  // One result item
  typedef struct packed {
    logic              kind;
    logic              hit;
    logic              evicted_valid;
    logic [IdW-1:0]    evicted_id;
    logic [CountW-1:0] held_count;
    logic [IdW-1:0]    list_id;
    logic              list_empty;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/fifo_distinct_recent_set_core.sv
// Top level: stream ports, capacity register and result output register.
//
// Usage:
//  - Input stream s_axis: tuser selects the operation (0 offer, 1 dump),
//    tdata[31:0] carries the id to offer. A transfer takes place when
//    tvalid and tready are both high.
//  - Output stream m_axis: tuser is the result kind (0 offer, 1 dump),
//    tlast marks the final result of an input item, tdata the other fields.
//  - cfg_we_i/cfg_wdata_i write the capacity (0 acts as 1, values above the
//    ring depth act as the depth); write only while the block is idle.
//  - An offer scans the held ids at one ring read per cycle; on a miss at
//    full capacity the oldest id is read and evicted before the result is
//    loaded. A dump reads each id, then presents it, newest first; the next
//    item can be taken in the cycle after the last result is accepted.
//  - s_axis_tready is high only while the sequencer is idle; one item is in
//    work at a time. The output register lets the next item be taken while
//    a result still waits on m_axis.
//  - If the receiver stalls, the result holds in the output register and
//    the sequencer waits before producing the next one.
//  - Reset empties the set, sets the capacity to the ring depth and drops
//    any pending result; ring contents are not cleared.
`default_nettype none

module fifo_distinct_recent_set_core
  import fdrs_pkg::*;
#(
  parameter int unsigned MaxEntries = DefMaxEntries
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Capacity register write
  input  wire logic                 cfg_we_i,
  input  wire logic [CountW-1:0]    cfg_wdata_i,
  // Input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,  // [31:0] id_value
  input  wire logic                 s_axis_tuser,  // [0] operation
  // Output stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata,  // [0] hit, [1] evicted_valid,
                                                   // [33:2] evicted_id,
                                                   // [39:34] held_count,
                                                   // [71:40] list_id,
                                                   // [72] list_empty, [79:73] zero
  output logic                      m_axis_tuser,  // [0] kind
  output logic                      m_axis_tlast
);

  logic [CountW-1:0] cap_q;
  logic [CountW-1:0] cap_eff;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CountW'(MaxEntries);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Clamp capacity to 1..depth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CountW'(1);
    end else if (cap_q > CountW'(MaxEntries)) begin
      cap_eff = CountW'(MaxEntries);
    end else begin
      cap_eff = cap_q;
    end
  end

  fdrs_seq #(
    .MaxEntries(MaxEntries)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_i      (cap_eff),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_id_i    (s_axis_tdata[IdW-1:0]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  // Pack result fields onto the stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tlast  = out_res_q.last;
  assign m_axis_tdata  = {7'b0,
                          out_res_q.list_empty,
                          out_res_q.list_id,
                          out_res_q.held_count,
                          out_res_q.evicted_id,
                          out_res_q.evicted_valid,
                          out_res_q.hit};

endmodule

`default_nettype wire

// File: hw/rtl/fdrs_store.sv
// Id ring storage with registered read port and the shared id comparator.
`default_nettype none

module fdrs_store
  import fdrs_pkg::*;
#(
  parameter int unsigned MaxEntries = DefMaxEntries,
  localparam int unsigned SlotW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [SlotW-1:0] rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [SlotW-1:0] wr_addr_i,
  input  wire logic [IdW-1:0]   wr_data_i,
  input  wire logic [IdW-1:0]   key_i,
  output logic      [IdW-1:0]   rd_data_o,
  output logic                  match_o
);

  logic [IdW-1:0] mem_q [MaxEntries];
  logic [IdW-1:0] rd_data_q;

  // One write and one registered read per cycle; entries hold no reset value
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

  // Shared compare of the last read entry against the offered id
  assign match_o = (rd_data_q == key_i);

endmodule

`default_nettype wire

// File: hw/rtl/fdrs_seq.sv
// Sequencer: membership scan, insert/evict and newest-first dump over the id ring.
`default_nettype none

module fdrs_seq
  import fdrs_pkg::*;
#(
  parameter int unsigned MaxEntries = DefMaxEntries,
  localparam int unsigned SlotW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1,
  localparam int unsigned CntW = $clog2(MaxEntries + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CountW-1:0] cap_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              in_op_i,
  input  wire logic [IdW-1:0]    in_id_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o
);

  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_MISS  = 7'b0000100,
    S_EVICT = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_DRD   = 7'b0100000,
    S_DOUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [SlotW-1:0] oldest_q, oldest_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             cmp_q, cmp_d;
  logic             op_q, op_d;
  logic [IdW-1:0]   id_q, id_d;
  logic             hit_q, hit_d;
  logic             ev_valid_q, ev_valid_d;
  logic [IdW-1:0]   ev_id_q, ev_id_d;

  logic             rd_en;
  logic [SlotW-1:0] rd_addr;
  logic             wr_en;
  logic [SlotW-1:0] wr_addr;
  logic [IdW-1:0]   rd_data;
  logic             match;
  logic             full;

  // Ring slot of the entry at a given age (0 is oldest)
  function automatic logic [SlotW-1:0] slot_of(input logic [SlotW-1:0] oldest,
                                               input logic [CntW-1:0] age);
    logic [SumW-1:0] sum;
    sum = SumW'(oldest) + SumW'(age);
    if (sum >= SumW'(MaxEntries)) begin
      sum = sum - SumW'(MaxEntries);
    end
    return sum[SlotW-1:0];
  endfunction

  assign full = (CountW'(fill_q) >= cap_i);

  fdrs_store #(
    .MaxEntries(MaxEntries)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(id_q),
    .key_i    (id_q),
    .rd_data_o(rd_data),
    .match_o  (match)
  );

  // Next-state and datapath control
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    oldest_d   = oldest_q;
    idx_d      = idx_q;
    cmp_d      = cmp_q;
    op_d       = op_q;
    id_d       = id_q;
    hit_d      = hit_q;
    ev_valid_d = ev_valid_q;
    ev_id_d    = ev_id_q;
    rd_en      = 1'b0;
    rd_addr    = oldest_q;
    wr_en      = 1'b0;
    wr_addr    = slot_of(oldest_q, fill_q);
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o      = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = in_op_i;
          id_d       = in_id_i;
          hit_d      = 1'b0;
          ev_valid_d = 1'b0;
          ev_id_d    = '0;
          cmp_d      = 1'b0;
          if (in_op_i == OpDump) begin
            idx_d   = fill_q;
            state_d = (fill_q == '0) ? S_EMIT : S_DRD;
          end else begin
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end

      // One read issued and one compare done per cycle
      S_SCAN: begin
        if (cmp_q && match) begin
          hit_d   = 1'b1;
          cmp_d   = 1'b0;
          state_d = S_EMIT;
        end else if (idx_q < fill_q) begin
          rd_en   = 1'b1;
          rd_addr = slot_of(oldest_q, idx_q);
          idx_d   = idx_q + CntW'(1);
          cmp_d   = 1'b1;
        end else if (cmp_q) begin
          cmp_d = 1'b0;
        end else begin
          state_d = S_MISS;
        end
      end

      // Miss: insert directly, or fetch the oldest id first when full
      S_MISS: begin
        if (full) begin
          rd_en      = 1'b1;
          rd_addr    = oldest_q;
          ev_valid_d = 1'b1;
          state_d    = S_EVICT;
        end else begin
          wr_en   = 1'b1;
          fill_d  = fill_q + CntW'(1);
          state_d = S_EMIT;
        end
      end

      S_EVICT: begin
        ev_id_d  = rd_data;
        wr_en    = 1'b1;
        oldest_d = slot_of(oldest_q, CntW'(1));
        state_d  = S_EMIT;
      end

      // Offer result, or the single empty-dump result
      S_EMIT: begin
        res_valid_o         = 1'b1;
        res_o.kind          = (op_q == OpDump) ? KindDump : KindOffer;
        res_o.hit           = hit_q;
        res_o.evicted_valid = ev_valid_q;
        res_o.evicted_id    = ev_id_q;
        res_o.held_count    = CountW'(fill_q);
        res_o.list_empty    = (op_q == OpDump);
        res_o.last          = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      S_DRD: begin
        rd_en   = 1'b1;
        rd_addr = slot_of(oldest_q, idx_q - CntW'(1));
        state_d = S_DOUT;
      end

      // Dump entry, newest first
      S_DOUT: begin
        res_valid_o      = 1'b1;
        res_o.kind       = KindDump;
        res_o.held_count = CountW'(fill_q);
        res_o.list_id    = rd_data;
        res_o.last       = (idx_q == CntW'(1));
        if (res_ready_i) begin
          idx_d   = idx_q - CntW'(1);
          state_d = (idx_q == CntW'(1)) ? S_IDLE : S_DRD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      oldest_q <= '0;
      idx_q    <= '0;
      cmp_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      idx_q    <= idx_d;
      cmp_q    <= cmp_d;
    end
  end

  // Item payload and result fields
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    hit_q      <= hit_d;
    ev_valid_q <= ev_valid_d;
    ev_id_q    <= ev_id_d;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MaxEntries))
    else $error("fill count exceeds ring depth");

  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SumW'(oldest_q) < SumW'(MaxEntries))
    else $error("oldest slot outside ring");

  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q >= $past(fill_q))
    else $error("fill count decreased");

  a_evict_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVICT) |=> (fill_q == $past(fill_q)))
    else $error("eviction changed fill count");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.hit) |-> !res_o.evicted_valid)
    else $error("hit result reports an eviction");
`endif

endmodule

`default_nettype wire
